[rtl/core/c2d_pkg.sv]
// shared types, constants and widths for the 3x3 convolution engine
`default_nettype none
package c2d_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;

   localparam int FILT_W = 4;
   localparam int CHAN_W = 4;
   localparam int DIM_W  = 6;
   localparam int TAP_W  = 2;

   localparam int CC_W  = 5;
   localparam int FC_W  = 5;
   localparam int DIMR_W = 7;

   localparam int COEFF_ADDR_W = FILT_W + CHAN_W + 2 * TAP_W;
   localparam int IMAGE_ADDR_W = CHAN_W + 2 * DIM_W;
   localparam int COEFF_DEPTH  = 1 << COEFF_ADDR_W;
   localparam int IMAGE_DEPTH  = 1 << IMAGE_ADDR_W;
   localparam int BIAS_DEPTH   = 1 << FILT_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [CC_W-1:0]   MAX_CHAN = CC_W'(16);
   localparam logic [FC_W-1:0]   MAX_FILT = FC_W'(16);
   localparam logic [DIMR_W-1:0] MAX_DIM  = DIMR_W'(64);
   localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(2);
   localparam logic [DIMR_W-1:0] KERNEL_REACH = DIMR_W'(2);

   typedef enum logic [1:0] {
      ACT_LOAD_COEFF = 2'd0,
      ACT_LOAD_BIAS  = 2'd1,
      ACT_LOAD_PIXEL = 2'd2,
      ACT_COMPUTE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_CHANNEL_COUNT = 3'd0,
      REG_FILTER_COUNT  = 3'd1,
      REG_IMAGE_WIDTH   = 3'd2,
      REG_IMAGE_HEIGHT  = 3'd3,
      REG_RELU_ENABLE   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [CC_W-1:0]   channel_count;
      logic [FC_W-1:0]   filter_count;
      logic [DIMR_W-1:0] image_width;
      logic [DIMR_W-1:0] image_height;
      logic              relu_enable;
   } cfg_type;

   typedef struct packed {
      logic                         coeff_we;
      logic                         bias_we;
      logic                         image_we;
      logic [FILT_W-1:0]            filter;
      logic [CHAN_W-1:0]            chan;
      logic [DIM_W-1:0]             row;
      logic [DIM_W-1:0]             col;
      logic signed [DATA_WIDTH-1:0] value;
   } store_wr_type;

   typedef struct packed {
      logic [FILT_W-1:0]       filter;
      logic [COEFF_ADDR_W-1:0] coeff_addr;
      logic [IMAGE_ADDR_W-1:0] image_addr;
   } store_rd_type;

   typedef struct packed {
      logic clear;
      logic acc_en;
   } mac_ctl_type;

endpackage
`default_nettype wire

[rtl/core/c2d_csr.sv]
// configuration registers behind the apb-style port
`default_nettype none
module c2d_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [c2d_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [c2d_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [c2d_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output c2d_pkg::cfg_type                     cfg
);

   c2d_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[c2d_pkg::CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            c2d_pkg::REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[c2d_pkg::CC_W-1:0];
            c2d_pkg::REG_FILTER_COUNT:  cfg_in.filter_count  = pwdata[c2d_pkg::FC_W-1:0];
            c2d_pkg::REG_IMAGE_WIDTH:   cfg_in.image_width   = pwdata[c2d_pkg::DIMR_W-1:0];
            c2d_pkg::REG_IMAGE_HEIGHT:  cfg_in.image_height  = pwdata[c2d_pkg::DIMR_W-1:0];
            c2d_pkg::REG_RELU_ENABLE:   cfg_in.relu_enable   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         c2d_pkg::REG_CHANNEL_COUNT: prdata[c2d_pkg::CC_W-1:0]   = cfg_ff.channel_count;
         c2d_pkg::REG_FILTER_COUNT:  prdata[c2d_pkg::FC_W-1:0]   = cfg_ff.filter_count;
         c2d_pkg::REG_IMAGE_WIDTH:   prdata[c2d_pkg::DIMR_W-1:0] = cfg_ff.image_width;
         c2d_pkg::REG_IMAGE_HEIGHT:  prdata[c2d_pkg::DIMR_W-1:0] = cfg_ff.image_height;
         c2d_pkg::REG_RELU_ENABLE:   prdata[0]                  = cfg_ff.relu_enable;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= c2d_pkg::CC_W'(1);
         cfg_ff.filter_count  <= c2d_pkg::FC_W'(1);
         cfg_ff.image_width   <= c2d_pkg::MAX_DIM;
         cfg_ff.image_height  <= c2d_pkg::MAX_DIM;
         cfg_ff.relu_enable   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/c2d_store.sv]
// coefficient, bias and image memories with registered read data
`default_nettype none
module c2d_store (
   input  wire logic                                   clock,
   input  wire c2d_pkg::store_wr_type                  wr,
   input  wire c2d_pkg::store_rd_type                  rd,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       coeff_data,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       image_data,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       bias_data
);

   logic signed [c2d_pkg::DATA_WIDTH-1:0] coeff_mem [c2d_pkg::COEFF_DEPTH];
   logic signed [c2d_pkg::DATA_WIDTH-1:0] image_mem [c2d_pkg::IMAGE_DEPTH];
   logic signed [c2d_pkg::DATA_WIDTH-1:0] bias_mem  [c2d_pkg::BIAS_DEPTH];

   logic signed [c2d_pkg::DATA_WIDTH-1:0] coeff_data_ff;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] image_data_ff;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] bias_data_ff;

   logic [c2d_pkg::COEFF_ADDR_W-1:0] coeff_wr_addr;
   logic [c2d_pkg::IMAGE_ADDR_W-1:0] image_wr_addr;

   assign coeff_wr_addr = {wr.filter, wr.chan,
                           wr.row[c2d_pkg::TAP_W-1:0], wr.col[c2d_pkg::TAP_W-1:0]};
   assign image_wr_addr = {wr.chan, wr.row, wr.col};

   assign coeff_data = coeff_data_ff;
   assign image_data = image_data_ff;
   assign bias_data  = bias_data_ff;

   always_ff @(posedge clock) begin
      if (wr.coeff_we) begin
         coeff_mem[coeff_wr_addr] <= wr.value;
      end
      coeff_data_ff <= coeff_mem[rd.coeff_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.image_we) begin
         image_mem[image_wr_addr] <= wr.value;
      end
      image_data_ff <= image_mem[rd.image_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.bias_we) begin
         bias_mem[wr.filter] <= wr.value;
      end
      bias_data_ff <= bias_mem[rd.filter];
   end

endmodule
`default_nettype wire

[rtl/core/c2d_mac.sv]
// shared multiply-accumulate unit with bias add and relu
`default_nettype none
module c2d_mac (
   input  wire logic                                   clock,
   input  wire c2d_pkg::mac_ctl_type                   ctl,
   input  wire logic                                   relu_enable,
   input  wire logic signed [c2d_pkg::DATA_WIDTH-1:0]  coeff_data,
   input  wire logic signed [c2d_pkg::DATA_WIDTH-1:0]  image_data,
   input  wire logic signed [c2d_pkg::DATA_WIDTH-1:0]  bias_data,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       result
);

   logic signed [c2d_pkg::PROD_WIDTH-1:0] mul;
   logic signed [c2d_pkg::PROD_WIDTH-1:0] mul_shr;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] prod_ff, prod_in;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] acc_ff, acc_in;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] sum;

   assign mul     = coeff_data * image_data;
   assign mul_shr = mul >>> c2d_pkg::FRAC_BITS;
   assign prod_in = mul_shr[c2d_pkg::DATA_WIDTH-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   assign sum    = acc_ff + bias_data;
   assign result = (relu_enable && sum[c2d_pkg::DATA_WIDTH-1]) ? '0 : sum;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

[rtl/core/c2d_seq.sv]
// sequencer that walks channels and kernel taps and drives the result word
`default_nettype none
module c2d_seq (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [1:0]                             action,
   input  wire logic [c2d_pkg::FILT_W-1:0]             filter_index,
   input  wire logic [c2d_pkg::DIM_W-1:0]              row_index,
   input  wire logic [c2d_pkg::DIM_W-1:0]              col_index,
   input  wire c2d_pkg::cfg_type                       cfg,
   input  wire logic signed [c2d_pkg::DATA_WIDTH-1:0]  mac_result,
   output logic                                        busy,
   output c2d_pkg::store_rd_type                       rd,
   output c2d_pkg::mac_ctl_type                        mac_ctl,
   output logic                                        rsp_valid,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       rsp_conv_value,
   output logic                                        rsp_bad_position
);

   c2d_pkg::state_type state_ff, state_in;

   logic [c2d_pkg::FILT_W-1:0] filt_ff, filt_in;
   logic [c2d_pkg::DIM_W-1:0]  row_ff, row_in;
   logic [c2d_pkg::DIM_W-1:0]  col_ff, col_in;
   logic                       bad_ff, bad_in;
   logic [c2d_pkg::CHAN_W-1:0] ch_ff, ch_in;
   logic [c2d_pkg::TAP_W-1:0]  ky_ff, ky_in;
   logic [c2d_pkg::TAP_W-1:0]  kx_ff, kx_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       prod_vld_ff, prod_vld_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                                  rsp_bad_ff, rsp_bad_in;

   logic                       accept;
   logic [c2d_pkg::CC_W-1:0]   nc;
   logic [c2d_pkg::FC_W-1:0]   nf;
   logic [c2d_pkg::DIMR_W-1:0] wd;
   logic [c2d_pkg::DIMR_W-1:0] ht;
   logic                       req_bad;
   logic                       last_tap;
   logic [c2d_pkg::DIM_W-1:0]  img_row;
   logic [c2d_pkg::DIM_W-1:0]  img_col;

   assign nc = (cfg.channel_count > c2d_pkg::MAX_CHAN) ? c2d_pkg::MAX_CHAN : cfg.channel_count;
   assign nf = (cfg.filter_count > c2d_pkg::MAX_FILT) ? c2d_pkg::MAX_FILT : cfg.filter_count;
   assign wd = (cfg.image_width > c2d_pkg::MAX_DIM) ? c2d_pkg::MAX_DIM : cfg.image_width;
   assign ht = (cfg.image_height > c2d_pkg::MAX_DIM) ? c2d_pkg::MAX_DIM : cfg.image_height;

   assign req_bad = ({1'b0, filter_index} >= nf) ||
                    (({1'b0, row_index} + c2d_pkg::KERNEL_REACH) >= ht) ||
                    (({1'b0, col_index} + c2d_pkg::KERNEL_REACH) >= wd);

   assign accept   = start && (state_ff == c2d_pkg::ST_IDLE) &&
                     (action == c2d_pkg::ACT_COMPUTE);
   assign last_tap = ({1'b0, ch_ff} == (nc - c2d_pkg::CC_W'(1))) &&
                     (ky_ff == c2d_pkg::TAP_LAST) && (kx_ff == c2d_pkg::TAP_LAST);

   assign img_row = row_ff + c2d_pkg::DIM_W'(ky_ff);
   assign img_col = col_ff + c2d_pkg::DIM_W'(kx_ff);

   assign rd.filter     = filt_in;
   assign rd.coeff_addr = {filt_ff, ch_ff, ky_ff, kx_ff};
   assign rd.image_addr = {ch_ff, img_row, img_col};

   assign busy             = (state_ff != c2d_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_conv_value   = rsp_value_ff;
   assign rsp_bad_position = rsp_bad_ff;

   always_comb begin
      state_in     = state_ff;
      filt_in      = filt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bad_in       = bad_ff;
      ch_in        = ch_ff;
      ky_in        = ky_ff;
      kx_in        = kx_ff;
      rd_vld_in    = 1'b0;
      prod_vld_in  = rd_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      mac_ctl.clear  = 1'b0;
      mac_ctl.acc_en = prod_vld_ff;
      case (state_ff)
         c2d_pkg::ST_IDLE: begin
            if (accept) begin
               filt_in = filter_index;
               row_in  = row_index;
               col_in  = col_index;
               bad_in  = req_bad;
               ch_in   = '0;
               ky_in   = '0;
               kx_in   = '0;
               mac_ctl.clear = 1'b1;
               if (req_bad || (nc == '0)) begin
                  state_in = c2d_pkg::ST_DRAIN;
               end else begin
                  state_in = c2d_pkg::ST_RUN;
               end
            end
         end
         c2d_pkg::ST_RUN: begin
            rd_vld_in = 1'b1;
            if (kx_ff == c2d_pkg::TAP_LAST) begin
               kx_in = '0;
               if (ky_ff == c2d_pkg::TAP_LAST) begin
                  ky_in = '0;
                  ch_in = ch_ff + c2d_pkg::CHAN_W'(1);
               end else begin
                  ky_in = ky_ff + c2d_pkg::TAP_W'(1);
               end
            end else begin
               kx_in = kx_ff + c2d_pkg::TAP_W'(1);
            end
            if (last_tap) begin
               state_in = c2d_pkg::ST_DRAIN;
            end
         end
         c2d_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = bad_ff ? '0 : mac_result;
               rsp_bad_in   = bad_ff;
               state_in     = c2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = c2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c2d_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      filt_ff      <= filt_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      bad_ff       <= bad_in;
      ch_ff        <= ch_in;
      ky_ff        <= ky_in;
      kx_ff        <= kx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

endmodule
`default_nettype wire

[rtl/core/conv2d_3x3_fixed_point_relu.sv]
// top level of the multichannel 3x3 fixed-point convolution engine
//
// request words are taken with start while busy is low. action selects a
// coefficient load, a bias load, a pixel load or an output request. loads
// are written into the memories at the accepting edge and give no result
// word, so busy stays low for them; a coefficient load with a row or
// column above 2 is dropped. an output request raises busy and walks every
// channel and 3x3 tap through one shared multiply-accumulate unit, one tap
// per cycle, behind a two-stage memory-read and product pipeline.
// a request with a bad filter or position, or with a channel count of zero,
// goes straight to the drain state and skips the walk. busy drops in the
// cycle the result word is shown. the result word is on rsp_conv_value and
// rsp_bad_position for exactly one cycle, marked by rsp_valid; the receiver
// cannot stall it. configuration goes through the apb-style port, one
// register per word address, and the user must write it only while the
// block is idle; the block itself does not enforce this.
// reset returns the registers to their defaults and the control to idle;
// the memories are not cleared and must be written before they are used.
`default_nettype none
module conv2d_3x3_fixed_point_relu (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [1:0]                             req_action,
   input  wire logic [c2d_pkg::FILT_W-1:0]             req_filter_index,
   input  wire logic [c2d_pkg::CHAN_W-1:0]             req_channel_index,
   input  wire logic [c2d_pkg::DIM_W-1:0]              req_row_index,
   input  wire logic [c2d_pkg::DIM_W-1:0]              req_col_index,
   input  wire logic signed [c2d_pkg::DATA_WIDTH-1:0]  req_load_value,
   output logic                                        rsp_valid,
   output logic signed [c2d_pkg::DATA_WIDTH-1:0]       rsp_conv_value,
   output logic                                        rsp_bad_position,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [c2d_pkg::CSR_ADDR_W-1:0]         paddr,
   input  wire logic [c2d_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic      [c2d_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                        pready
);

   c2d_pkg::cfg_type      cfg;
   c2d_pkg::store_wr_type wr;
   c2d_pkg::store_rd_type rd;
   c2d_pkg::mac_ctl_type  mac_ctl;

   logic signed [c2d_pkg::DATA_WIDTH-1:0] coeff_data;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] image_data;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] bias_data;
   logic signed [c2d_pkg::DATA_WIDTH-1:0] mac_result;
   logic                                  load_ok;

   assign load_ok = start && !busy;

   assign wr.coeff_we = load_ok && (req_action == c2d_pkg::ACT_LOAD_COEFF) &&
                        (req_row_index <= c2d_pkg::DIM_W'(c2d_pkg::TAP_LAST)) &&
                        (req_col_index <= c2d_pkg::DIM_W'(c2d_pkg::TAP_LAST));
   assign wr.bias_we  = load_ok && (req_action == c2d_pkg::ACT_LOAD_BIAS);
   assign wr.image_we = load_ok && (req_action == c2d_pkg::ACT_LOAD_PIXEL);
   assign wr.filter   = req_filter_index;
   assign wr.chan     = req_channel_index;
   assign wr.row      = req_row_index;
   assign wr.col      = req_col_index;
   assign wr.value    = req_load_value;

   c2d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   c2d_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd         (rd),
      .coeff_data (coeff_data),
      .image_data (image_data),
      .bias_data  (bias_data)
   );

   c2d_mac u_mac (
      .clock       (clock),
      .ctl         (mac_ctl),
      .relu_enable (cfg.relu_enable),
      .coeff_data  (coeff_data),
      .image_data  (image_data),
      .bias_data   (bias_data),
      .result      (mac_result)
   );

   c2d_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .action           (req_action),
      .filter_index     (req_filter_index),
      .row_index        (req_row_index),
      .col_index        (req_col_index),
      .cfg              (cfg),
      .mac_result       (mac_result),
      .busy             (busy),
      .rd               (rd),
      .mac_ctl          (mac_ctl),
      .rsp_valid        (rsp_valid),
      .rsp_conv_value   (rsp_conv_value),
      .rsp_bad_position (rsp_bad_position)
   );

endmodule
`default_nettype wire

[dv/conv2d_3x3_fixed_point_relu_tb.sv]
// testbench for the 3x3 convolution engine: directed and random request words against a predictor
module conv2d_3x3_fixed_point_relu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import c2d_pkg::*;

   localparam int N_FILT      = int'(MAX_FILT);
   localparam int N_CHAN      = int'(MAX_CHAN);
   localparam int N_DIM       = int'(MAX_DIM);
   localparam int KSIZE       = int'(TAP_LAST) + 1;
   localparam int REACH       = int'(KERNEL_REACH);
   localparam int TAPS        = KSIZE * KSIZE;
   localparam int ITEM_TARGET = 1650;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         bad;
   } conv_out_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_action;
   logic [FILT_W-1:0]            req_filter_index;
   logic [CHAN_W-1:0]            req_channel_index;
   logic [DIM_W-1:0]             req_row_index;
   logic [DIM_W-1:0]             req_col_index;
   logic signed [DATA_WIDTH-1:0] req_load_value;
   logic                         rsp_valid;
   logic signed [DATA_WIDTH-1:0] rsp_conv_value;
   logic                         rsp_bad_position;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [CSR_ADDR_W-1:0]        paddr;
   logic [CSR_DATA_W-1:0]        pwdata;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   conv2d_3x3_fixed_point_relu u_top (.*);

   // shadow stores and settings
   logic signed [DATA_WIDTH-1:0] coeff_mem [N_FILT*N_CHAN*TAPS];
   bit                           coeff_set [N_FILT*N_CHAN*TAPS];
   logic signed [DATA_WIDTH-1:0] bias_mem  [N_FILT];
   bit                           bias_set  [N_FILT];
   logic signed [DATA_WIDTH-1:0] pixel_mem [N_CHAN*N_DIM*N_DIM];
   bit                           pixel_set [N_CHAN*N_DIM*N_DIM];

   logic [CC_W-1:0]   cfg_chan;
   logic [FC_W-1:0]   cfg_filt;
   logic [DIMR_W-1:0] cfg_width;
   logic [DIMR_W-1:0] cfg_height;
   logic              cfg_relu;

   conv_out_type expected_pixels[$];
   int err_count;
   int items_sent;
   int outputs_seen;
   int bad_seen;
   int settings_used;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("timeout with %0d output words outstanding", expected_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      err_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic int clamp_to(int v, int top);
      return (v > top) ? top : v;
   endfunction

   function automatic int coeff_slot(int f, int c, int ky, int kx);
      return ((f * N_CHAN + c) * TAPS) + ky * KSIZE + kx;
   endfunction

   function automatic int pixel_slot(int c, int r, int k);
      return (c * N_DIM + r) * N_DIM + k;
   endfunction

   function automatic bit out_of_range(int f, int r, int k);
      return f >= clamp_to(int'(cfg_filt), N_FILT) ||
             r + REACH >= clamp_to(int'(cfg_height), N_DIM) ||
             k + REACH >= clamp_to(int'(cfg_width), N_DIM);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return -16'sd1;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   function automatic int near_pick(int top);
      if ($urandom_range(0, 2) != 0) begin
         return $urandom_range(0, (top < 4) ? top : 4);
      end
      return $urandom_range(0, top);
   endfunction

   // sum of floored fixed-point products, wrapped, plus bias and optional clamp
   function automatic conv_out_type predict_conv(int f, int r, int k);
      conv_out_type                 res;
      logic signed [DATA_WIDTH-1:0] cf;
      logic signed [DATA_WIDTH-1:0] px;
      logic signed [PROD_WIDTH-1:0] prod;
      logic signed [PROD_WIDTH-1:0] scaled;
      logic [DATA_WIDTH-1:0]        acc;
      int                           nc;
      res.value = '0;
      res.bad   = 1'b1;
      if (out_of_range(f, r, k)) begin
         return res;
      end
      nc  = clamp_to(int'(cfg_chan), N_CHAN);
      acc = '0;
      for (int ch = 0; ch < nc; ch++) begin
         for (int ky = 0; ky < KSIZE; ky++) begin
            for (int kx = 0; kx < KSIZE; kx++) begin
               cf     = coeff_mem[coeff_slot(f, ch, ky, kx)];
               px     = pixel_mem[pixel_slot(ch, r + ky, k + kx)];
               prod   = cf * px;
               scaled = prod >>> FRAC_BITS;
               acc    = acc + scaled[DATA_WIDTH-1:0];
            end
         end
      end
      acc = acc + bias_mem[f];
      if (cfg_relu && acc[DATA_WIDTH-1]) begin
         acc = '0;
      end
      res.value = acc;
      res.bad   = 1'b0;
      return res;
   endfunction

   // returns 0 for a load that the block must ignore
   function automatic bit store_word(action_type act, int f, int c, int r, int k,
                                     logic signed [DATA_WIDTH-1:0] v);
      case (act)
         ACT_LOAD_COEFF: begin
            if (r >= KSIZE || k >= KSIZE) begin
               return 1'b0;
            end
            coeff_mem[coeff_slot(f, c, r, k)] = v;
            coeff_set[coeff_slot(f, c, r, k)] = 1'b1;
         end
         ACT_LOAD_BIAS: begin
            bias_mem[f] = v;
            bias_set[f] = 1'b1;
         end
         ACT_LOAD_PIXEL: begin
            pixel_mem[pixel_slot(c, r, k)] = v;
            pixel_set[pixel_slot(c, r, k)] = 1'b1;
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   task automatic send_request(input action_type act, input int f, input int c, input int r,
                               input int k, input logic signed [DATA_WIDTH-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_action        = act;
      req_filter_index  = FILT_W'(f);
      req_channel_index = CHAN_W'(c);
      req_row_index     = DIM_W'(r);
      req_col_index     = DIM_W'(k);
      req_load_value    = v;
      start             = 1'b1;
      do @(posedge clock); while (busy);
      if (act == ACT_COMPUTE) begin
         expected_pixels.push_back(predict_conv(f, r, k));
      end
      items_sent += store_word(act, f, c, r, k, v);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] got;
      logic [CSR_DATA_W-1:0] want;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (idx)
         REG_CHANNEL_COUNT: begin
            cfg_chan = value[CC_W-1:0];
            want     = CSR_DATA_W'(cfg_chan);
         end
         REG_FILTER_COUNT: begin
            cfg_filt = value[FC_W-1:0];
            want     = CSR_DATA_W'(cfg_filt);
         end
         REG_IMAGE_WIDTH: begin
            cfg_width = value[DIMR_W-1:0];
            want      = CSR_DATA_W'(cfg_width);
         end
         REG_IMAGE_HEIGHT: begin
            cfg_height = value[DIMR_W-1:0];
            want       = CSR_DATA_W'(cfg_height);
         end
         default: begin
            cfg_relu = value[0];
            want     = CSR_DATA_W'(cfg_relu);
         end
      endcase
      // read back
      psel  = 1'b1;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== want) begin
         report_mismatch($sformatf("register %s reads %0h, wrote %0h", idx.name(), got, want));
      end
   endtask

   task automatic wait_idle();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input int ch, input int filt, input int w, input int h,
                            input int relu);
      wait_idle();
      csr_write(REG_CHANNEL_COUNT, ch);
      csr_write(REG_FILTER_COUNT, filt);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_RELU_ENABLE, relu);
      settings_used++;
   endtask

   // loads every entry a compute at (f, r, k) reads that was never written
   task automatic cover_window(input int f, input int r, input int k);
      int nc;
      nc = clamp_to(int'(cfg_chan), N_CHAN);
      if (!bias_set[f]) begin
         send_request(ACT_LOAD_BIAS, f, $urandom_range(0, 15), $urandom_range(0, 63),
                      $urandom_range(0, 63), pick_value());
      end
      for (int ch = 0; ch < nc; ch++) begin
         for (int ky = 0; ky < KSIZE; ky++) begin
            for (int kx = 0; kx < KSIZE; kx++) begin
               if (!coeff_set[coeff_slot(f, ch, ky, kx)]) begin
                  send_request(ACT_LOAD_COEFF, f, ch, ky, kx, pick_value());
               end
               if (!pixel_set[pixel_slot(ch, r + ky, k + kx)]) begin
                  send_request(ACT_LOAD_PIXEL, $urandom_range(0, 15), ch, r + ky, k + kx,
                               pick_value());
               end
            end
         end
      end
   endtask

   task automatic compute_at(input int f, input int r, input int k);
      send_request(ACT_COMPUTE, f, $urandom_range(0, 15), r, k, pick_value());
   endtask

   task automatic test_bad_requests();
      configure(1, 2, 5, 6, 0);
      compute_at(2, 0, 0);
      compute_at(15, 0, 0);
      compute_at(0, 4, 0);
      compute_at(0, 63, 0);
      compute_at(0, 0, 3);
      compute_at(0, 0, 63);
      configure(1, 0, 2, 64, 1);
      compute_at(0, 0, 0);
      configure(31, 31, 127, 0, 0);
      compute_at(15, 0, 0);
      configure(1, 16, 1, 127, 0);
      compute_at(0, 0, 0);
   endtask

   task automatic test_extreme_window();
      logic signed [DATA_WIDTH-1:0] coeff_vals [TAPS];
      logic signed [DATA_WIDTH-1:0] pixel_vals [TAPS];
      coeff_vals = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1, 16'sd256, -16'sd256, 16'sd0,
                     16'sh7fff, 16'sh8000};
      pixel_vals = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd256, 16'sd1, -16'sd1,
                     16'sd0, 16'sh8000};
      configure(1, 1, 3, 3, 0);
      send_request(ACT_LOAD_BIAS, 0, 15, 63, 63, 16'sh8000);
      for (int t = 0; t < TAPS; t++) begin
         send_request(ACT_LOAD_COEFF, 0, 0, t / KSIZE, t % KSIZE, coeff_vals[t]);
         send_request(ACT_LOAD_PIXEL, 15, 0, t / KSIZE, t % KSIZE, pixel_vals[t]);
      end
      // sum wraps past the negative end
      compute_at(0, 0, 0);
      send_request(ACT_LOAD_BIAS, 0, 0, 0, 0, 16'sd0);
      compute_at(0, 0, 0);
      configure(1, 1, 3, 3, 1);
      compute_at(0, 0, 0);
      // kernel taps out of range must not alias onto real taps
      send_request(ACT_LOAD_COEFF, 0, 0, 4, 1, pick_value());
      send_request(ACT_LOAD_COEFF, 0, 0, 1, 5, pick_value());
      send_request(ACT_LOAD_COEFF, 15, 15, 63, 63, pick_value());
      send_request(ACT_LOAD_PIXEL, 15, 15, 63, 63, pick_value());
      compute_at(0, 0, 0);
   endtask

   task automatic test_zero_channels();
      configure(0, 16, 64, 64, 1);
      send_request(ACT_LOAD_BIAS, 15, 0, 0, 0, -16'sd5);
      compute_at(15, 61, 61);
      compute_at(15, 62, 61);
      configure(0, 16, 64, 64, 0);
      compute_at(15, 61, 61);
   endtask

   task automatic random_step();
      int sel;
      int f;
      int r;
      int k;
      int nf;
      int nc;
      int h;
      int w;
      action_type act;
      sel = $urandom_range(0, 99);
      nf  = clamp_to(int'(cfg_filt), N_FILT);
      nc  = clamp_to(int'(cfg_chan), N_CHAN);
      h   = clamp_to(int'(cfg_height), N_DIM);
      w   = clamp_to(int'(cfg_width), N_DIM);
      if (sel < 60 && nf > 0 && h >= KSIZE && w >= KSIZE) begin
         f = ($urandom_range(0, 3) != 0) ? $urandom_range(0, (nf < 2) ? 0 : 1)
                                         : $urandom_range(0, nf - 1);
         r = near_pick(h - KSIZE);
         k = near_pick(w - KSIZE);
         // overwrite something the window uses
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
               0: send_request(ACT_LOAD_BIAS, f, $urandom_range(0, 15), 0, 0, pick_value());
               1: send_request(ACT_LOAD_COEFF, f, $urandom_range(0, (nc > 0) ? nc - 1 : 0),
                               $urandom_range(0, KSIZE - 1), $urandom_range(0, KSIZE - 1),
                               pick_value());
               default: send_request(ACT_LOAD_PIXEL, $urandom_range(0, 15),
                                     $urandom_range(0, (nc > 0) ? nc - 1 : 0),
                                     r + $urandom_range(0, KSIZE - 1),
                                     k + $urandom_range(0, KSIZE - 1), pick_value());
            endcase
         end
         cover_window(f, r, k);
         compute_at(f, r, k);
      end else if (sel < 80) begin
         act = action_type'($urandom_range(0, 2));
         r = (act == ACT_LOAD_COEFF && $urandom_range(0, 1)) ? $urandom_range(0, 3)
                                                              : $urandom_range(0, 63);
         k = (act == ACT_LOAD_COEFF && $urandom_range(0, 1)) ? $urandom_range(0, 3)
                                                              : $urandom_range(0, 63);
         send_request(act, $urandom_range(0, 15), $urandom_range(0, 15), r, k, pick_value());
      end else begin
         f = $urandom_range(0, 15);
         r = $urandom_range(0, 1) ? near_pick(63) : $urandom_range(0, 63);
         k = $urandom_range(0, 1) ? near_pick(63) : $urandom_range(0, 63);
         if (!out_of_range(f, r, k)) begin
            cover_window(f, r, k);
         end
         compute_at(f, r, k);
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      int steps;
      int phase_end;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: configure(16, 16, 64, 64, $urandom_range(0, 1));
            1: configure(1, 1, 3, 3, $urandom_range(0, 1));
            default: configure(
               ($urandom_range(0, 7) == 0) ? 0 :
               ($urandom_range(0, 6) == 0) ? $urandom_range(16, 31) : $urandom_range(1, 3),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 31 :
               ($urandom_range(0, 6) == 0) ? 16 : $urandom_range(1, 4),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
               ($urandom_range(0, 6) == 0) ? $urandom_range(64, 127) : $urandom_range(3, 8),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
               ($urandom_range(0, 6) == 0) ? $urandom_range(64, 127) : $urandom_range(3, 8),
               $urandom_range(0, 1));
         endcase
         steps     = $urandom_range(30, 120);
         phase_end = items_sent + PHASE_ITEMS;
         for (int s = 0; s < steps && items_sent < phase_end && items_sent < ITEM_TARGET; s++)
         begin
            random_step();
         end
         phase++;
      end
   endtask

   always @(posedge clock) begin : check_outputs
      conv_out_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("output word with nothing expected");
         end else begin
            want = expected_pixels.pop_front();
            outputs_seen++;
            if (want.bad) begin
               bad_seen++;
            end
            if (rsp_conv_value !== want.value) begin
               report_mismatch($sformatf("conv_value %0d, expected %0d",
                                         rsp_conv_value, want.value));
            end
            if (rsp_bad_position !== want.bad) begin
               report_mismatch($sformatf("bad_position %b, expected %b",
                                         rsp_bad_position, want.bad));
            end
         end
      end
   end

   initial begin
      int guard;
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = '0;
      req_filter_index  = '0;
      req_channel_index = '0;
      req_row_index     = '0;
      req_col_index     = '0;
      req_load_value    = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      cfg_chan          = CC_W'(1);
      cfg_filt          = FC_W'(1);
      cfg_width         = MAX_DIM;
      cfg_height        = MAX_DIM;
      cfg_relu          = 1'b0;
      err_count         = 0;
      items_sent        = 0;
      outputs_seen      = 0;
      bad_seen          = 0;
      settings_used     = 0;
      burst_left        = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_bad_requests();
      test_extreme_window();
      test_zero_channels();
      test_random_traffic();

      guard = 0;
      while (expected_pixels.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d output words never came", expected_pixels.size()));
      end
      $display("sent %0d request words under %0d register settings",
               items_sent, settings_used);
      $display("checked %0d output words, %0d of them flagged out of range",
               outputs_seen, bad_seen);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/c2d_pkg.sv
rtl/core/c2d_csr.sv
rtl/core/c2d_store.sv
rtl/core/c2d_mac.sv
rtl/core/c2d_seq.sv
rtl/core/conv2d_3x3_fixed_point_relu.sv
dv/conv2d_3x3_fixed_point_relu_tb.sv
